// File: hdl/assert_macros.svh
// assertion macros of the shift light rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// File: hdl/crsl_pkg.sv
// types, codes and constants of the can rpm shift light
// no dependencies; imported by every module of the block
package crsl_pkg;

  localparam int unsigned SPEED_W    = 14;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned ID_W       = 11;
  localparam int unsigned FRAME_ID_W = 29;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RAW_W      = 2 * BYTE_W;
  localparam int unsigned PROD_W     = RAW_W + 3;
  localparam int unsigned NUM_W      = SPEED_W + BYTE_W;
  localparam int unsigned DIV_IDX_W  = 3;
  localparam int unsigned LEDS       = 8;

  localparam logic [AGE_W-1:0]     AGE_MAX    = '1;
  localparam logic [LEN_W-1:0]     MIN_LEN    = 4'd4;
  localparam logic [BYTE_W-1:0]    LEVEL_FULL = 8'hFF;
  localparam logic [DIV_IDX_W-1:0] DIV_FIRST  = 3'd7;

  localparam logic [LEDS-1:0] PAIR1_MASK = 8'h81;
  localparam logic [LEDS-1:0] PAIR2_MASK = 8'h42;
  localparam logic [LEDS-1:0] PAIR3_MASK = 8'h24;
  localparam logic [LEDS-1:0] PAIR4_MASK = 8'h18;
  localparam logic [LEDS-1:0] ALL_MASK   = 8'hFF;

  // reset values of the configuration registers
  localparam logic                RST_CAN_ENABLE      = 1'b1;
  localparam logic [ID_W-1:0]     RST_SPEED_FRAME_ID  = 11'd790;
  localparam logic [SPEED_W-1:0]  RST_SPEED_LIMIT     = 14'd9000;
  localparam logic [AGE_W-1:0]    RST_STALE_LIMIT_MS  = 16'd2000;
  localparam logic [AGE_W-1:0]    RST_BLINK_PERIOD_MS = 16'd100;
  localparam logic [SPEED_W-1:0]  RST_LIT_START       = 14'd3000;
  localparam logic [SPEED_W-1:0]  RST_GRADIENT_START  = 14'd6000;
  localparam logic [SPEED_W-1:0]  RST_REDLINE         = 14'd7100;

  typedef enum logic [1:0] {
    ACT_FRAME  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_REDRAW = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAN_ENABLE      = 3'd0,
    CFG_SPEED_FRAME_ID  = 3'd1,
    CFG_SPEED_LIMIT     = 3'd2,
    CFG_STALE_LIMIT_MS  = 3'd3,
    CFG_BLINK_PERIOD_MS = 3'd4,
    CFG_LIT_START       = 3'd5,
    CFG_GRADIENT_START  = 3'd6,
    CFG_REDLINE         = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic               can_enable;
    logic [ID_W-1:0]    speed_frame_id;
    logic [SPEED_W-1:0] speed_limit;
    logic [AGE_W-1:0]   stale_limit_ms;
    logic [AGE_W-1:0]   blink_period_ms;
    logic [SPEED_W-1:0] lit_start;
    logic [SPEED_W-1:0] gradient_start;
    logic [SPEED_W-1:0] redline;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic                 take;
    logic                 div_step;
    logic [DIV_IDX_W-1:0] div_idx;
    logic                 out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic redraw;
    logic grad;
  } stat_t;

endpackage

// File: hdl/crsl_cfg.sv
// configuration register bank of the shift light
// depends on crsl_pkg
module crsl_cfg import crsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CAN_ENABLE:      cfg_d.can_enable      = cfg_data_i[0];
        CFG_SPEED_FRAME_ID:  cfg_d.speed_frame_id  = cfg_data_i[ID_W-1:0];
        CFG_SPEED_LIMIT:     cfg_d.speed_limit     = cfg_data_i[SPEED_W-1:0];
        CFG_STALE_LIMIT_MS:  cfg_d.stale_limit_ms  = cfg_data_i[AGE_W-1:0];
        CFG_BLINK_PERIOD_MS: cfg_d.blink_period_ms = cfg_data_i[AGE_W-1:0];
        CFG_LIT_START:       cfg_d.lit_start       = cfg_data_i[SPEED_W-1:0];
        CFG_GRADIENT_START:  cfg_d.gradient_start  = cfg_data_i[SPEED_W-1:0];
        CFG_REDLINE:         cfg_d.redline         = cfg_data_i[SPEED_W-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.can_enable      <= RST_CAN_ENABLE;
      cfg_q.speed_frame_id  <= RST_SPEED_FRAME_ID;
      cfg_q.speed_limit     <= RST_SPEED_LIMIT;
      cfg_q.stale_limit_ms  <= RST_STALE_LIMIT_MS;
      cfg_q.blink_period_ms <= RST_BLINK_PERIOD_MS;
      cfg_q.lit_start       <= RST_LIT_START;
      cfg_q.gradient_start  <= RST_GRADIENT_START;
      cfg_q.redline         <= RST_REDLINE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/crsl_dp.sv
// datapath of the shift light: speed decode, ages, color, pair mask, divider
// depends on crsl_pkg; driven by crsl_ctrl through cmd_t / stat_t
module crsl_dp import crsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic [1:0]            action_i,
  input  logic                  is_extended_i,
  input  logic                  is_remote_i,
  input  logic [FRAME_ID_W-1:0] frame_id_i,
  input  logic [LEN_W-1:0]      frame_length_i,
  input  logic [BYTE_W-1:0]     speed_low_byte_i,
  input  logic [BYTE_W-1:0]     speed_high_byte_i,
  output logic [BYTE_W-1:0]     red_level_o,
  output logic [BYTE_W-1:0]     green_level_o,
  output logic [LEDS-1:0]       lit_mask_o,
  output logic [SPEED_W-1:0]    engine_speed_o
);

  // state
  logic [SPEED_W-1:0] speed_q, speed_d;
  logic [AGE_W-1:0]   speed_age_q, speed_age_d;
  logic               blink_q, blink_d;
  logic [AGE_W-1:0]   blink_age_q, blink_age_d;

  // staged result and divider
  logic [BYTE_W-1:0]  res_red_q, res_green_q;
  logic [LEDS-1:0]    res_mask_q;
  logic [SPEED_W-1:0] res_speed_q;
  logic               res_grad_q;
  logic [NUM_W-1:0]   rem_q;
  logic [SPEED_W-1:0] span_q;
  logic [BYTE_W-1:0]  quo_q;

  logic [BYTE_W-1:0]  red_q, green_q;
  logic [LEDS-1:0]    mask_q;
  logic [SPEED_W-1:0] speed_out_q;

  logic               is_frame, is_tick, is_redraw;
  logic [RAW_W-1:0]   raw;
  logic [PROD_W-1:0]  prod;
  logic [SPEED_W-1:0] decoded, clamped;
  logic               frame_hit;
  logic               stale;
  logic [SPEED_W-1:0] s_cur;
  logic [AGE_W-1:0]   s4, r1, r2, r3, r4;
  logic [LEDS-1:0]    pair_mask;
  logic               below_lit, below_grad, le_red, in_grad, in_blink;
  logic               blink_toggle, blink_next;
  logic [SPEED_W-1:0] grad_diff, span;
  logic [NUM_W-1:0]   num, trial;
  logic               fits;
  logic [BYTE_W-1:0]  pre_red, pre_green;
  logic [LEDS-1:0]    pre_mask;

  assign is_frame  = (action_i == ACT_FRAME);
  assign is_tick   = (action_i == ACT_TICK);
  assign is_redraw = (action_i == ACT_REDRAW);

  // speed word times 5/32
  assign raw       = {speed_high_byte_i, speed_low_byte_i};
  assign prod      = {1'b0, raw, 2'b00} + {3'b000, raw};
  assign decoded   = prod[PROD_W-1:5];
  assign clamped   = (decoded > cfg_i.speed_limit) ? cfg_i.speed_limit : decoded;
  assign frame_hit = cfg_i.can_enable && !is_extended_i && !is_remote_i &&
                     (frame_id_i == FRAME_ID_W'(cfg_i.speed_frame_id)) &&
                     (frame_length_i >= MIN_LEN);

  assign stale = (speed_q != '0) && (speed_age_q > cfg_i.stale_limit_ms);
  assign s_cur = stale ? '0 : speed_q;

  // pairs >= k exactly when 4*s >= k*redline
  assign s4 = {s_cur, 2'b00};
  assign r1 = {2'b00, cfg_i.redline};
  assign r2 = {1'b0, cfg_i.redline, 1'b0};
  assign r3 = r1 + r2;
  assign r4 = {cfg_i.redline, 2'b00};
  assign pair_mask = ((s4 >= r1) ? PAIR1_MASK : '0) | ((s4 >= r2) ? PAIR2_MASK : '0) |
                     ((s4 >= r3) ? PAIR3_MASK : '0) | ((s4 >= r4) ? PAIR4_MASK : '0);

  assign below_lit  = (s_cur < cfg_i.lit_start);
  assign below_grad = (s_cur < cfg_i.gradient_start);
  assign le_red     = (s_cur <= cfg_i.redline);
  assign in_grad    = !below_lit && !below_grad && le_red;
  assign in_blink   = !below_lit && !below_grad && !le_red;

  assign blink_toggle = (blink_age_q >= cfg_i.blink_period_ms);
  assign blink_next   = blink_q ^ blink_toggle;

  // gradient numerator (s - start) * 255
  assign grad_diff = s_cur - cfg_i.gradient_start;
  assign span      = cfg_i.redline - cfg_i.gradient_start;
  assign num       = {grad_diff, 8'h00} - {8'h00, grad_diff};

  always_comb begin
    pre_red   = '0;
    pre_green = '0;
    pre_mask  = pair_mask;
    priority if (below_lit) begin
      pre_red   = '0;
    end else if (below_grad) begin
      pre_green = LEVEL_FULL;
    end else if (le_red) begin
      pre_red   = '0;
    end else begin
      pre_red   = blink_next ? LEVEL_FULL : '0;
      pre_mask  = ALL_MASK;
    end
  end

  assign stat_o.redraw = is_redraw;
  assign stat_o.grad   = in_grad;

  always_comb begin
    speed_d     = speed_q;
    speed_age_d = speed_age_q;
    blink_d     = blink_q;
    blink_age_d = blink_age_q;
    if (cmd_i.take) begin
      if (is_frame && frame_hit) begin
        speed_d     = clamped;
        speed_age_d = '0;
      end
      if (is_tick) begin
        if (speed_age_q != AGE_MAX) speed_age_d = speed_age_q + 1'b1;
        if (blink_age_q != AGE_MAX) blink_age_d = blink_age_q + 1'b1;
      end
      if (is_redraw) begin
        speed_d = s_cur;
        if (in_blink && blink_toggle) begin
          blink_d     = blink_next;
          blink_age_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      speed_age_q <= '0;
      blink_q     <= 1'b0;
      blink_age_q <= '0;
    end else begin
      speed_q     <= speed_d;
      speed_age_q <= speed_age_d;
      blink_q     <= blink_d;
      blink_age_q <= blink_age_d;
    end
  end

  // restoring divider, one quotient bit per step, msb first
  assign trial = NUM_W'(span_q) << cmd_i.div_idx;
  assign fits  = (rem_q >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_redraw) begin
      res_red_q   <= pre_red;
      res_green_q <= pre_green;
      res_mask_q  <= pre_mask;
      res_speed_q <= s_cur;
      res_grad_q  <= in_grad;
      rem_q       <= num;
      span_q      <= span;
    end else if (cmd_i.div_step) begin
      if (fits) rem_q <= rem_q - trial;
      quo_q <= {quo_q[BYTE_W-2:0], fits};
    end
    if (cmd_i.out_load) begin
      red_q       <= res_grad_q ? quo_q : res_red_q;
      green_q     <= res_grad_q ? ~quo_q : res_green_q;
      mask_q      <= res_mask_q;
      speed_out_q <= res_speed_q;
    end
  end

  assign red_level_o    = red_q;
  assign green_level_o  = green_q;
  assign lit_mask_o     = mask_q;
  assign engine_speed_o = speed_out_q;

endmodule

// File: hdl/crsl_ctrl.sv
// controller of the shift light: input handshake, divider sequencing, output word
// depends on crsl_pkg and assert_macros.svh
`include "assert_macros.svh"
module crsl_ctrl import crsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_DONE = 2'd2
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_IDX_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 take, out_free;

  assign take     = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.take  = take;
    cmd_o.div_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take && stat_i.redraw) begin
          state_d = stat_i.grad ? ST_DIV : ST_DONE;
          cnt_d   = DIV_FIRST;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // a pending word is never overwritten
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load && out_valid_q && out_stall_i,
    "output word overwritten while stalled")
  // an accepted redraw always leaves idle
  `ASSERT_CLK(a_redraw_busy, clk_i, rst_ni,
    (take && stat_i.redraw) |=> (state_q != ST_IDLE), "redraw did not start")
  // divider steps count down one per cycle
  `ASSERT_CLK(a_div_count, clk_i, rst_ni,
    (state_q == ST_DIV && cnt_q != '0) |=>
      (state_q == ST_DIV && cnt_q == $past(cnt_q) - 1'b1), "divider step skipped")

endmodule

// File: hdl/can_rpm_shift_light_top.sv
// top level of the can rpm shift light
// depends on crsl_pkg, crsl_cfg, crsl_ctrl and crsl_dp
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  action, frame flags, id, length, bytes
//   out      output     out_valid_o / out_stall_i red, green, lit mask, engine speed
//   cfg      input      cfg_we_i                cfg_index_i, cfg_data_i
//
// a frame, tick or ignored action does not stall the input; the next word is taken right after
// a redraw outside the gradient holds the input while the controller is in its done state
// a gradient redraw holds it through the divide state, whose 8 steps run the restoring divider, and the done state
// a redraw also waits while the previous output word is still stalled
// reset is asynchronous, active low, and clears speed, ages and blink state
module can_rpm_shift_light_top import crsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic                  is_extended_i,
  input  logic                  is_remote_i,
  input  logic [FRAME_ID_W-1:0] frame_id_i,
  input  logic [LEN_W-1:0]      frame_length_i,
  input  logic [BYTE_W-1:0]     speed_low_byte_i,
  input  logic [BYTE_W-1:0]     speed_high_byte_i,
  // output words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [BYTE_W-1:0]     red_level_o,
  output logic [BYTE_W-1:0]     green_level_o,
  output logic [LEDS-1:0]       lit_mask_o,
  output logic [SPEED_W-1:0]    engine_speed_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // register bank; the user must write it only while the block is idle, the block does not enforce this
  crsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // sequencer: accepts words, steps the divider, loads the output word
  crsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // speed, ages, color selection and the gradient divider
  crsl_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .action_i          (action_i),
    .is_extended_i     (is_extended_i),
    .is_remote_i       (is_remote_i),
    .frame_id_i        (frame_id_i),
    .frame_length_i    (frame_length_i),
    .speed_low_byte_i  (speed_low_byte_i),
    .speed_high_byte_i (speed_high_byte_i),
    .red_level_o       (red_level_o),
    .green_level_o     (green_level_o),
    .lit_mask_o        (lit_mask_o),
    .engine_speed_o    (engine_speed_o)
  );

endmodule

// File: tb/sv/can_rpm_shift_light_top_test.sv
// self-checking testbench of the can rpm shift light top level
// depends on crsl_pkg and can_rpm_shift_light_top; predicts each redraw word in its own code
// runs directed, bus disable, edge settings, backpressure and random tests in turn
module can_rpm_shift_light_top_test;
  import crsl_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // idle cycles after the last redraw word before a register write or the end
  localparam int DRAIN_CYCLES = 16;
  // cycles with no accepted word before the run is called hung
  localparam int QUIET_LIMIT = 4000;
  localparam int unsigned SPEED_TOP = 10239;

  typedef struct {
    logic [1:0]            act;
    logic                  ext;
    logic                  rtr;
    logic [FRAME_ID_W-1:0] id;
    logic [LEN_W-1:0]      len;
    logic [BYTE_W-1:0]     lo;
    logic [BYTE_W-1:0]     hi;
  } in_word_t;

  typedef struct {
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [LEDS-1:0]    mask;
    logic [SPEED_W-1:0] speed;
  } light_t;

  // dut ports
  logic                  clk_i;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i          = '0;
  logic                  is_extended_i     = 1'b0;
  logic                  is_remote_i       = 1'b0;
  logic [FRAME_ID_W-1:0] frame_id_i        = '0;
  logic [LEN_W-1:0]      frame_length_i    = '0;
  logic [BYTE_W-1:0]     speed_low_byte_i  = '0;
  logic [BYTE_W-1:0]     speed_high_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i       = 1'b0;
  logic [BYTE_W-1:0]     red_level_o;
  logic [BYTE_W-1:0]     green_level_o;
  logic [LEDS-1:0]       lit_mask_o;
  logic [SPEED_W-1:0]    engine_speed_o;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;

  // shadow copy of the registers and the light state
  cfg_t               settings;
  logic [SPEED_W-1:0] cur_speed;
  logic [AGE_W-1:0]   speed_age;
  logic               blink_lit;
  logic [AGE_W-1:0]   blink_age;

  // redraw words still to come out of the block, oldest first
  light_t pending_lights[$];

  int fails      = 0;
  int burst_left = 0;
  int gap_max    = 0;   // longest sender gap in cycles, 0 for back-to-back words
  int hold_req   = 0;   // asks the receiver for a long holdoff

  can_rpm_shift_light_top u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // light prediction: updates the shadow state for one accepted word and queues
  // the expected output word of a redraw
  // ---------------------------------------------------------------------------
  function automatic void compute_light(input in_word_t w);
    int unsigned raw, v, s, pairs, span, t;
    light_t      lt;
    case (w.act)
      ACT_FRAME: begin
        // only standard data frames with the speed id and at least four bytes count
        if (settings.can_enable && !w.ext && !w.rtr &&
            w.id == FRAME_ID_W'(settings.speed_frame_id) && w.len >= MIN_LEN) begin
          raw = 32'({w.hi, w.lo});
          v   = (raw * 5) >> 5;
          if (v > 32'(settings.speed_limit)) v = 32'(settings.speed_limit);
          cur_speed = v[SPEED_W-1:0];
          speed_age = '0;
        end
      end
      ACT_TICK: begin
        if (speed_age != AGE_MAX) speed_age++;
        if (blink_age != AGE_MAX) blink_age++;
      end
      ACT_REDRAW: begin
        if (cur_speed != 0 && speed_age > settings.stale_limit_ms) cur_speed = '0;
        s = 32'(cur_speed);
        // a zero redline saturates the pair count
        if (settings.redline == 0) begin
          pairs = 4;
        end else begin
          pairs = (s * 4) / 32'(settings.redline);
          if (pairs > 4) pairs = 4;
        end
        lt.red   = '0;
        lt.green = '0;
        if (s < 32'(settings.lit_start)) begin
          lt.green = '0;
        end else if (s < 32'(settings.gradient_start)) begin
          lt.green = LEVEL_FULL;
        end else if (s <= 32'(settings.redline)) begin
          span = 32'(settings.redline) - 32'(settings.gradient_start);
          t = (span == 0) ? 255 : ((s - 32'(settings.gradient_start)) * 255) / span;
          if (t > 255) t = 255;
          lt.red   = t[BYTE_W-1:0];
          lt.green = LEVEL_FULL - t[BYTE_W-1:0];
        end else begin
          // over redline the whole strip blinks red
          if (blink_age >= settings.blink_period_ms) begin
            blink_lit = ~blink_lit;
            blink_age = '0;
          end
          lt.red = blink_lit ? LEVEL_FULL : '0;
          pairs  = 4;
        end
        lt.mask = '0;
        if (pairs >= 1) lt.mask |= PAIR1_MASK;
        if (pairs >= 2) lt.mask |= PAIR2_MASK;
        if (pairs >= 3) lt.mask |= PAIR3_MASK;
        if (pairs >= 4) lt.mask |= PAIR4_MASK;
        lt.speed = cur_speed;
        pending_lights.push_back(lt);
      end
      default: ;  // unused action: no effect
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // word builders
  // ---------------------------------------------------------------------------
  // every field random, so that fields a word does not use still toggle
  function automatic in_word_t junk_word(input logic [1:0] act);
    in_word_t w;
    w.act = act;
    w.ext = 1'($urandom_range(0, 1));
    w.rtr = 1'($urandom_range(0, 1));
    w.id  = FRAME_ID_W'($urandom);
    w.len = LEN_W'($urandom_range(0, 15));
    w.lo  = BYTE_W'($urandom);
    w.hi  = BYTE_W'($urandom);
    return w;
  endfunction

  // matching speed frame whose decoded value is spd (before the clamp)
  function automatic in_word_t speed_frame(input int unsigned spd, input int unsigned len);
    in_word_t    w;
    int unsigned raw;
    w     = junk_word(ACT_FRAME);
    w.ext = 1'b0;
    w.rtr = 1'b0;
    w.id  = FRAME_ID_W'(settings.speed_frame_id);
    w.len = LEN_W'(len);
    raw   = (spd * 32 + 4) / 5;
    if (raw > 65535) raw = 65535;
    {w.hi, w.lo} = raw[15:0];
    return w;
  endfunction

  // speed close to one of the current thresholds, or anywhere
  function automatic int unsigned near_threshold();
    int unsigned base;
    int          v;
    case ($urandom_range(0, 5))
      0:       base = 32'(settings.lit_start);
      1:       base = 32'(settings.gradient_start);
      2:       base = 32'(settings.redline);
      3:       base = 32'(settings.speed_limit);
      4:       base = 0;
      default: base = $urandom_range(0, SPEED_TOP);
    endcase
    v = int'(base) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > int'(SPEED_TOP)) v = int'(SPEED_TOP);
    return unsigned'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: offers one word and returns at the edge where it is taken
  // ---------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i        <= 1'b1;
    action_i          <= w.act;
    is_extended_i     <= w.ext;
    is_remote_i       <= w.rtr;
    frame_id_i        <= w.id;
    frame_length_i    <= w.len;
    speed_low_byte_i  <= w.lo;
    speed_high_byte_i <= w.hi;
    do @(posedge clk_i); while (in_stall_o);
    compute_light(w);
  endtask

  // stop sending and wait until the block has nothing left to do
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_lights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register write; bits above the register width carry junk the block must drop
  task automatic write_reg(input cfg_idx_e idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] m;
    logic [CFG_DATA_W-1:0] d;
    case (idx)
      CFG_CAN_ENABLE:      begin m = 16'h0001; settings.can_enable      = val[0];    end
      CFG_SPEED_FRAME_ID:  begin m = 16'h07FF; settings.speed_frame_id  = val[10:0]; end
      CFG_SPEED_LIMIT:     begin m = 16'h3FFF; settings.speed_limit     = val[13:0]; end
      CFG_STALE_LIMIT_MS:  begin m = 16'hFFFF; settings.stale_limit_ms  = val[15:0]; end
      CFG_BLINK_PERIOD_MS: begin m = 16'hFFFF; settings.blink_period_ms = val[15:0]; end
      CFG_LIT_START:       begin m = 16'h3FFF; settings.lit_start       = val[13:0]; end
      CFG_GRADIENT_START:  begin m = 16'h3FFF; settings.gradient_start  = val[13:0]; end
      default:             begin m = 16'h3FFF; settings.redline         = val[13:0]; end
    endcase
    d = (val[15:0] & m) | (16'($urandom) & ~m);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input int unsigned en, input int unsigned id,
                                input int unsigned lim, input int unsigned stale,
                                input int unsigned blink, input int unsigned lit,
                                input int unsigned grad, input int unsigned red);
    settle();
    write_reg(CFG_CAN_ENABLE, en);
    write_reg(CFG_SPEED_FRAME_ID, id);
    write_reg(CFG_SPEED_LIMIT, lim);
    write_reg(CFG_STALE_LIMIT_MS, stale);
    write_reg(CFG_BLINK_PERIOD_MS, blink);
    write_reg(CFG_LIT_START, lit);
    write_reg(CFG_GRADIENT_START, grad);
    write_reg(CFG_REDLINE, red);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // field extremes and the color bands under the reset settings
  task automatic test_directed();
    in_word_t w;
    gap_max = 4;
    send_word(junk_word(ACT_REDRAW));                  // nothing decoded yet
    w = speed_frame(0, 8);
    {w.hi, w.lo} = 16'hFFFF;                           // clamped to the speed limit
    send_word(w);
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(3000, 4));                   // first green speed
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(2999, 4));                   // black, pair still shown
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(6000, 8));                   // gradient start
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(7100, 8));                   // exactly redline
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(7101, 8));                   // blink band
    send_word(junk_word(ACT_REDRAW));
    w = speed_frame(5000, 8);
    w.ext = 1'b1;                                      // extended frame dropped
    send_word(w);
    w = speed_frame(5000, 8);
    w.rtr = 1'b1;                                      // remote frame dropped
    send_word(w);
    send_word(speed_frame(5000, 3));                   // too short
    w = speed_frame(5000, 8);
    w.id[ID_W] = 1'b1;                                 // wide id never matches
    send_word(w);
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(5000, 15));                  // long length code
    send_word(junk_word(ACT_REDRAW));
    send_word(junk_word(ACT_UNUSED));
    send_word(speed_frame(0, 4));
    send_word(junk_word(ACT_REDRAW));
  endtask

  // frames are dropped while the bus is down
  task automatic test_bus_disable();
    apply_settings(0, 790, 9000, 2000, 100, 3000, 6000, 7100);
    send_word(speed_frame(5000, 8));
    send_word(junk_word(ACT_REDRAW));
    settle();
    write_reg(CFG_CAN_ENABLE, 1);
    send_word(speed_frame(5000, 8));
    send_word(junk_word(ACT_REDRAW));
  endtask

  // empty gradient, zero blink period, stale speed, zero limit and zero redline
  task automatic test_edge_settings();
    apply_settings(1, 790, SPEED_TOP, 3, 0, 0, 500, 500);
    send_word(speed_frame(500, 4));
    send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(600, 4));
    repeat (3) send_word(junk_word(ACT_REDRAW));       // toggles on every redraw
    repeat (3) send_word(junk_word(ACT_TICK));
    send_word(junk_word(ACT_REDRAW));                  // age equals the limit: kept
    send_word(junk_word(ACT_TICK));
    send_word(junk_word(ACT_REDRAW));                  // now stale
    apply_settings(1, 0, 0, 100, 5, 0, 0, 0);
    send_word(speed_frame(4000, 8));
    send_word(junk_word(ACT_REDRAW));
    apply_settings(1, 0, SPEED_TOP, 100, 5, 0, 0, 0);
    send_word(speed_frame(100, 8));
    repeat (6) send_word(junk_word(ACT_TICK));
    repeat (2) send_word(junk_word(ACT_REDRAW));
  endtask

  // receiver holds off for a long stretch while redraws keep coming
  task automatic test_backpressure();
    apply_settings(1, 790, 9000, 2000, 100, 3000, 6000, 7100);
    gap_max = 0;
    send_word(speed_frame(6500, 8));
    hold_req = 300;
    repeat (20) send_word(junk_word(ACT_REDRAW));
    send_word(speed_frame(7500, 8));
    repeat (10) send_word(junk_word(ACT_REDRAW));
  endtask

  // mostly well-formed traffic with random content, some broken frames and noise
  task automatic run_mix(input int count);
    int       n, pick, burst;
    in_word_t w;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        w = speed_frame(near_threshold(), $urandom_range(4, 15));
        if ($urandom_range(0, 2) == 0) {w.hi, w.lo} = 16'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       w.ext = 1'b1;
            1:       w.rtr = 1'b1;
            2:       w.len = LEN_W'($urandom_range(0, 3));
            default: w.id[$urandom_range(ID_W, FRAME_ID_W - 1)] = 1'b1;
          endcase
        end
        send_word(w);
        n++;
      end else if (pick < 40) begin
        send_word(junk_word(ACT_FRAME));
      end else if (pick < 68) begin
        // tick runs long enough to reach small stale and blink limits
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 60) : 1;
        repeat (burst) send_word(junk_word(ACT_TICK));
        n += burst;
      end else if (pick < 95) begin
        send_word(junk_word(ACT_REDRAW));
        n++;
      end else begin
        send_word(junk_word(ACT_UNUSED));
      end
    end
  endtask

  task automatic test_random();
    int          phase;
    int unsigned red, grad;
    for (phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0: begin
          red  = $urandom_range(50, SPEED_TOP);
          grad = $urandom_range(0, red - 1);
          apply_settings(1, $urandom_range(0, 2047), $urandom_range(red, SPEED_TOP),
                         $urandom_range(1, 40), $urandom_range(0, 20),
                         $urandom_range(0, grad), grad, red);
        end
        1: apply_settings(1, 0, SPEED_TOP, 1, 0, 0, 0, $urandom_range(0, 1));
        2: apply_settings(1, 2047, SPEED_TOP, 65534, 65534, SPEED_TOP, SPEED_TOP - 1,
                          SPEED_TOP);
        3: begin
          red = $urandom_range(1, SPEED_TOP);
          apply_settings(1, $urandom_range(0, 2047), SPEED_TOP, $urandom_range(5, 30),
                         $urandom_range(1, 10), $urandom_range(0, red), red, red);
        end
        default: begin
          // thresholds in any order, full register width
          apply_settings(($urandom_range(0, 3) != 0) ? 1 : 0, $urandom_range(0, 2047),
                         $urandom_range(0, 16383), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 16383),
                         $urandom_range(0, 16383), $urandom_range(0, 16383));
        end
      endcase
      case ($urandom_range(0, 2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase
      run_mix(95);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, switching density at random cycles
  // ---------------------------------------------------------------------------
  initial begin : stall_pattern
    int mode_left, pct, hold_left;
    mode_left = 0;
    pct       = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output check: each taken word against the oldest expected light
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    light_t lt;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lights.size() == 0) begin
        $error("output word with no redraw pending");
        fails++;
      end else begin
        lt = pending_lights.pop_front();
        if (red_level_o !== lt.red) begin
          $error("red_level: expected %0d, got %0d", lt.red, red_level_o);
          fails++;
        end
        if (green_level_o !== lt.green) begin
          $error("green_level: expected %0d, got %0d", lt.green, green_level_o);
          fails++;
        end
        if (lit_mask_o !== lt.mask) begin
          $error("lit_mask: expected %02h, got %02h", lt.mask, lit_mask_o);
          fails++;
        end
        if (engine_speed_o !== lt.speed) begin
          $error("engine_speed: expected %0d, got %0d", lt.speed, engine_speed_o);
          fails++;
        end
      end
    end
  end

  // hang detection: too long without any word taken on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : run_tests
    // shadow state starts at the reset values
    settings.can_enable      = RST_CAN_ENABLE;
    settings.speed_frame_id  = RST_SPEED_FRAME_ID;
    settings.speed_limit     = RST_SPEED_LIMIT;
    settings.stale_limit_ms  = RST_STALE_LIMIT_MS;
    settings.blink_period_ms = RST_BLINK_PERIOD_MS;
    settings.lit_start       = RST_LIT_START;
    settings.gradient_start  = RST_GRADIENT_START;
    settings.redline         = RST_REDLINE;
    cur_speed = '0;
    speed_age = '0;
    blink_lit = 1'b0;
    blink_age = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bus_disable();
    test_edge_settings();
    test_backpressure();
    test_random();
    settle();
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/crsl_pkg.sv
hdl/crsl_cfg.sv
hdl/crsl_dp.sv
hdl/crsl_ctrl.sv
hdl/can_rpm_shift_light_top.sv
tb/sv/can_rpm_shift_light_top_test.sv
